// File: design/apid_pkg.sv
// Shared types and constants for the altitude PID with rotor mixer.
// Holds the configuration register layout, register indexes, reset values and the
// stage-to-stage structs. No dependencies.
package apid_pkg;

  // Width of the saturating error integral.
  localparam int INTEGRAL_BITS = 40;
  localparam int LO_BITS       = INTEGRAL_BITS / 2;
  localparam int HI_BITS       = INTEGRAL_BITS - LO_BITS;

  // The integral product is compared against 2^60, so it is never narrower than 61 bits.
  localparam int IPROD_BITS = ((24 + INTEGRAL_BITS) > 61) ? (24 + INTEGRAL_BITS) : 61;
  localparam int TERM_BITS  = 62;
  localparam int SUM_BITS   = 63;
  localparam int ADJ_BITS   = SUM_BITS - 16;

  localparam logic [IPROD_BITS-1:0] ITERM_LIMIT = IPROD_BITS'(64'd1 << 60);

  localparam logic [16:0]        ONE_Q16  = 17'd65536;
  localparam logic signed [13:0] MIX_GAIN = 14'sd3277;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TARGET_ALTITUDE  = 3'd0;
  localparam logic [2:0] CFG_SMOOTHING_WEIGHT = 3'd1;
  localparam logic [2:0] CFG_P_GAIN           = 3'd2;
  localparam logic [2:0] CFG_I_GAIN           = 3'd3;
  localparam logic [2:0] CFG_D_GAIN           = 3'd4;
  localparam logic [2:0] CFG_BASE_SPEED       = 3'd5;
  localparam logic [2:0] CFG_MIN_SPEED        = 3'd6;
  localparam logic [2:0] CFG_MAX_SPEED        = 3'd7;

  typedef struct packed {
    logic [22:0] target_altitude;
    logic [16:0] smoothing_weight;
    logic [23:0] p_gain;
    logic [23:0] i_gain;
    logic [23:0] d_gain;
    logic [22:0] base_speed;
    logic [22:0] min_speed;
    logic [22:0] max_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    target_altitude:  23'd768,
    smoothing_weight: 17'd52429,
    p_gain:           24'd98304,
    i_gain:           24'd328,
    d_gain:           24'd1310720,
    base_speed:       23'd179200,
    min_speed:        23'd0,
    max_speed:        23'd230400
  };

  // A control tick leaving the front stage.
  typedef struct packed {
    logic                            valid;
    logic signed [24:0]              err;
    logic signed [24:0]              delta;
    logic signed [INTEGRAL_BITS-1:0] integral;
    logic                            sat;
    logic signed [11:0]              roll_angle;
    logic signed [11:0]              pitch_angle;
  } front_t;

  // A control tick leaving the control law, ready for clamping and mixing.
  typedef struct packed {
    logic                       valid;
    logic signed [ADJ_BITS-1:0] adj;
    logic signed [11:0]         roll_c;
    logic signed [11:0]         pitch_c;
    logic signed [24:0]         err;
    logic                       sat;
  } mix_t;

endpackage

// File: design/apid_if.sv
// Valid/ready channel interfaces for the altitude PID block.
// One interface for input requests and one for results; no dependencies.
interface apid_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [23:0] altitude_sample;
  logic signed [11:0] roll_angle;
  logic signed [11:0] pitch_angle;

  modport source (output valid, output opcode, output altitude_sample,
                  output roll_angle, output pitch_angle, input ready);
  modport sink   (input valid, input opcode, input altitude_sample,
                  input roll_angle, input pitch_angle, output ready);
endinterface

interface apid_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] rotor_speed_1;
  logic signed [23:0] rotor_speed_2;
  logic signed [23:0] rotor_speed_3;
  logic signed [23:0] rotor_speed_4;
  logic signed [24:0] altitude_error;
  logic               integral_saturated;

  modport source (output valid, output rotor_speed_1, output rotor_speed_2,
                  output rotor_speed_3, output rotor_speed_4, output altitude_error,
                  output integral_saturated, input ready);
  modport sink   (input valid, input rotor_speed_1, input rotor_speed_2,
                  input rotor_speed_3, input rotor_speed_4, input altitude_error,
                  input integral_saturated, output ready);
endinterface

// File: design/apid_cfg.sv
// Configuration register file for the altitude PID block.
// Uses apid_pkg for the register layout, indexes and reset values.
module apid_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_data,
  output apid_pkg::cfg_t cfg
);

  apid_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= apid_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apid_pkg::CFG_TARGET_ALTITUDE:  cfg_r.target_altitude  <= cfg_data[22:0];
        apid_pkg::CFG_SMOOTHING_WEIGHT: cfg_r.smoothing_weight <= cfg_data[16:0];
        apid_pkg::CFG_P_GAIN:           cfg_r.p_gain           <= cfg_data;
        apid_pkg::CFG_I_GAIN:           cfg_r.i_gain           <= cfg_data;
        apid_pkg::CFG_D_GAIN:           cfg_r.d_gain           <= cfg_data;
        apid_pkg::CFG_BASE_SPEED:       cfg_r.base_speed       <= cfg_data[22:0];
        apid_pkg::CFG_MIN_SPEED:        cfg_r.min_speed        <= cfg_data[22:0];
        apid_pkg::CFG_MAX_SPEED:        cfg_r.max_speed        <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/apid_front.sv
// Input register and loop state: altitude smoother, tick error, delta and integral.
// Uses apid_pkg and the apid_in_if channel interface.
module apid_front (
  input  logic            clk,
  input  logic            rst_n,
  input  apid_pkg::cfg_t  cfg,
  apid_in_if.sink         in_ch,
  output apid_pkg::front_t front,
  input  logic            dn_ready
);

  localparam int IB = apid_pkg::INTEGRAL_BITS;
  localparam logic signed [IB-1:0] IMAX = {1'b0, {(IB-1){1'b1}}};
  localparam logic signed [IB-1:0] IMIN = {1'b1, {(IB-1){1'b0}}};

  logic               in_valid_r;
  logic               in_valid_nxt;
  logic               opcode_r;
  logic signed [23:0] sample_r;
  logic signed [11:0] roll_r;
  logic signed [11:0] pitch_r;

  logic signed [23:0]   smooth_r;
  logic signed [23:0]   smooth_nxt;
  logic signed [23:0]   prev_r;
  logic signed [IB-1:0] integ_r;
  logic signed [IB-1:0] integ_nxt;

  logic                 accept;
  logic                 leave;
  logic [16:0]          w_eff;
  logic signed [24:0]   diff;
  logic signed [42:0]   sm_prod;
  logic signed [42:0]   sm_rnd;
  logic signed [24:0]   err;
  logic signed [24:0]   delta;
  logic signed [IB:0]   isum;

  // A sample leaves at once; a tick waits for room in the control law.
  assign leave        = in_valid_r && (!opcode_r || dn_ready);
  assign in_ch.ready  = !in_valid_r || leave;
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_valid_nxt = accept ? 1'b1 : (leave ? 1'b0 : in_valid_r);

  // Smoother written as s + w*(x - s), rounded to the nearest 1/256 m.
  always_comb begin
    w_eff      = (cfg.smoothing_weight > apid_pkg::ONE_Q16) ? apid_pkg::ONE_Q16
                                                            : cfg.smoothing_weight;
    diff       = {sample_r[23], sample_r} - {smooth_r[23], smooth_r};
    sm_prod    = $signed({1'b0, w_eff}) * diff;
    sm_rnd     = sm_prod + 43'sd32768;
    smooth_nxt = smooth_r + sm_rnd[39:16];
  end

  always_comb begin
    err   = {2'b00, cfg.target_altitude} - {smooth_r[23], smooth_r};
    delta = {smooth_r[23], smooth_r} - {prev_r[23], prev_r};
    isum  = {integ_r[IB-1], integ_r} + {{(IB-24){err[24]}}, err};
    if (isum[IB] != isum[IB-1]) begin
      integ_nxt = isum[IB] ? IMIN : IMAX;
    end else begin
      integ_nxt = isum[IB-1:0];
    end
  end

  always_comb begin
    front.valid       = in_valid_r && opcode_r;
    front.err         = err;
    front.delta       = delta;
    front.integral    = integ_nxt;
    front.sat         = (integ_nxt == IMAX) || (integ_nxt == IMIN);
    front.roll_angle  = roll_r;
    front.pitch_angle = pitch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r <= in_ch.opcode;
      sample_r <= in_ch.altitude_sample;
      roll_r   <= in_ch.roll_angle;
      pitch_r  <= in_ch.pitch_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= '0;
      prev_r   <= '0;
      integ_r  <= '0;
    end else if (leave) begin
      if (!opcode_r) begin
        smooth_r <= smooth_nxt;
      end else begin
        prev_r  <= smooth_r;
        integ_r <= integ_nxt;
      end
    end
  end

endmodule

// File: design/apid_law.sv
// Pipelined PID law: gain products, saturated integral term, sum and rounding.
// Also rounds the roll and pitch corrections. Uses apid_pkg.
module apid_law (
  input  logic             clk,
  input  logic             rst_n,
  input  apid_pkg::cfg_t   cfg,
  input  apid_pkg::front_t front,
  output logic             up_ready,
  output apid_pkg::mix_t   law,
  input  logic             dn_ready
);

  localparam int IB  = apid_pkg::INTEGRAL_BITS;
  localparam int LO  = apid_pkg::LO_BITS;
  localparam int HI  = apid_pkg::HI_BITS;
  localparam int IPB = apid_pkg::IPROD_BITS;
  localparam int TB  = apid_pkg::TERM_BITS;
  localparam int SB  = apid_pkg::SUM_BITS;

  typedef struct packed {
    logic                 valid;
    logic signed [49:0]   pe;
    logic signed [49:0]   de;
    logic [24+LO-1:0]     pl;
    logic [24+HI-1:0]     ph;
    logic                 neg;
    logic signed [11:0]   roll_c;
    logic signed [11:0]   pitch_c;
    logic signed [24:0]   err;
    logic                 sat;
  } prod_t;

  typedef struct packed {
    logic                 valid;
    logic signed [50:0]   pd;
    logic signed [TB-1:0] iterm;
    logic signed [11:0]   roll_c;
    logic signed [11:0]   pitch_c;
    logic signed [24:0]   err;
    logic                 sat;
  } term_t;

  apid_pkg::front_t s2_r;
  prod_t            s3_r, s3_nxt;
  term_t            s4_r, s4_nxt;
  apid_pkg::mix_t   s5_r, s5_nxt;

  logic s2_load, s3_load, s4_load, s5_load;

  assign s5_load  = !s5_r.valid || dn_ready;
  assign s4_load  = !s4_r.valid || s5_load;
  assign s3_load  = !s3_r.valid || s4_load;
  assign s2_load  = !s2_r.valid || s3_load;
  assign up_ready = s2_load;

  // Products of the three gains; the integral product is split in two halves.
  logic [IB-1:0]      mag;
  logic signed [25:0] roll_p, pitch_p;
  always_comb begin
    mag           = s2_r.integral[IB-1] ? (~s2_r.integral + 1'b1) : s2_r.integral;
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.pe     = $signed({1'b0, cfg.p_gain}) * s2_r.err;
    s3_nxt.de     = $signed({1'b0, cfg.d_gain}) * s2_r.delta;
    s3_nxt.pl     = cfg.i_gain * mag[LO-1:0];
    s3_nxt.ph     = cfg.i_gain * mag[IB-1:LO];
    s3_nxt.neg    = s2_r.integral[IB-1];
    roll_p        = apid_pkg::MIX_GAIN * s2_r.roll_angle + 26'sd32768;
    pitch_p       = apid_pkg::MIX_GAIN * s2_r.pitch_angle + 26'sd32768;
    s3_nxt.roll_c  = {{2{roll_p[25]}}, roll_p[25:16]};
    s3_nxt.pitch_c = {{2{pitch_p[25]}}, pitch_p[25:16]};
    s3_nxt.err    = s2_r.err;
    s3_nxt.sat    = s2_r.sat;
  end

  // Integral term limited to 2^60 in magnitude, then signed; the D product is subtracted from the P product.
  logic [IPB-1:0] iprod, ilim;
  logic [TB-1:0]  tmag;
  always_comb begin
    iprod          = (IPB'(s3_r.ph) << LO) + IPB'(s3_r.pl);
    ilim           = (iprod > apid_pkg::ITERM_LIMIT) ? apid_pkg::ITERM_LIMIT : iprod;
    tmag           = {1'b0, ilim[60:0]};
    s4_nxt.valid   = s3_r.valid;
    s4_nxt.pd      = {s3_r.pe[49], s3_r.pe} - {s3_r.de[49], s3_r.de};
    s4_nxt.iterm   = s3_r.neg ? -$signed(tmag) : $signed(tmag);
    s4_nxt.roll_c  = s3_r.roll_c;
    s4_nxt.pitch_c = s3_r.pitch_c;
    s4_nxt.err     = s3_r.err;
    s4_nxt.sat     = s3_r.sat;
  end

  // Sum of the three terms, rounded to the nearest step by floor(x + 1/2).
  logic signed [SB-1:0] sum;
  always_comb begin
    sum            = {{(SB-51){s4_r.pd[50]}}, s4_r.pd}
                   + {{(SB-TB){s4_r.iterm[TB-1]}}, s4_r.iterm}
                   + SB'(32768);
    s5_nxt.valid   = s4_r.valid;
    s5_nxt.adj     = sum[SB-1:16];
    s5_nxt.roll_c  = s4_r.roll_c;
    s5_nxt.pitch_c = s4_r.pitch_c;
    s5_nxt.err     = s4_r.err;
    s5_nxt.sat     = s4_r.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
      s5_r.valid <= 1'b0;
    end else begin
      if (s2_load) s2_r <= front;
      if (s3_load) s3_r <= s3_nxt;
      if (s4_load) s4_r <= s4_nxt;
      if (s5_load) s5_r <= s5_nxt;
    end
  end

  assign law = s5_r;

endmodule

// File: design/apid_mix.sv
// Speed clamp, rotor mixer and result register.
// Uses apid_pkg and the apid_out_if channel interface.
module apid_mix (
  input  logic           clk,
  input  logic           rst_n,
  input  apid_pkg::cfg_t cfg,
  input  apid_pkg::mix_t law,
  output logic           up_ready,
  apid_out_if.source     out_ch
);

  localparam int AB = apid_pkg::ADJ_BITS;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? 24'sh800000 : 24'sh7fffff;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  logic               out_valid_r;
  logic               load;
  logic signed [23:0] r1_r, r2_r, r3_r, r4_r;
  logic signed [23:0] r1_nxt, r2_nxt, r3_nxt, r4_nxt;
  logic signed [24:0] err_r;
  logic               sat_r;

  logic signed [AB:0] spd, spd_c, mn, mx;
  logic signed [24:0] sp, rc, pc;

  assign up_ready = !out_valid_r || out_ch.ready;
  assign load     = up_ready && law.valid;

  // Raise to the minimum first, then lower to the maximum, so the maximum wins.
  always_comb begin
    mn    = {{(AB+1-23){1'b0}}, cfg.min_speed};
    mx    = {{(AB+1-23){1'b0}}, cfg.max_speed};
    spd   = {law.adj[AB-1], law.adj} + {{(AB+1-23){1'b0}}, cfg.base_speed};
    spd_c = (spd < mn) ? mn : spd;
    if (spd_c > mx) begin
      spd_c = mx;
    end
    sp     = {2'b00, spd_c[22:0]};
    rc     = {{13{law.roll_c[11]}}, law.roll_c};
    pc     = {{13{law.pitch_c[11]}}, law.pitch_c};
    r1_nxt = sat24(sp - rc + pc);
    r2_nxt = sat24(sp + rc + pc);
    r3_nxt = sat24(sp + rc - pc);
    r4_nxt = sat24(sp - rc - pc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= law.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r1_r  <= r1_nxt;
      r2_r  <= r2_nxt;
      r3_r  <= r3_nxt;
      r4_r  <= r4_nxt;
      err_r <= law.err;
      sat_r <= law.sat;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.rotor_speed_1      = r1_r;
  assign out_ch.rotor_speed_2      = r2_r;
  assign out_ch.rotor_speed_3      = r3_r;
  assign out_ch.rotor_speed_4      = r4_r;
  assign out_ch.altitude_error     = err_r;
  assign out_ch.integral_saturated = sat_r;

endmodule

// File: design/altitude_pid_with_rotor_mix_top.sv
// Altitude hold for a quadrotor: PID on collective speed plus a roll/pitch rotor mixer.
//
// The in_ch channel carries one request per valid/ready handshake. A request with
// opcode 0 is an altimeter sample: it updates the smoothed altitude and produces no
// result. A request with opcode 1 is a control tick: it produces exactly one result on
// out_ch holding four rotor speeds, the altitude error and the integral saturation flag.
// The cfg_ port writes one of eight registers per cycle in which cfg_we is high; write
// only while no tick is in flight.
//
// Throughput is one request per clock while out_ch.ready does not stall the pipeline. A
// tick's result reaches out_ch through the input register, four control-law registers
// (front result, gain products, integral term limit, sum and rounding) and the result
// register. The loop state (smoothed altitude, last tick altitude, integral) is updated
// as a request leaves the input register, so back-to-back requests always see the
// state the previous one left.
//
// Synchronous reset loads the register defaults, zeroes the loop state and empties the
// pipeline. When the receiver holds out_ch.ready low, results queue in the pipeline
// stages; input requests keep flowing until every stage is full, and samples are
// still taken as long as the input register can drain.
module altitude_pid_with_rotor_mix_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  apid_in_if.sink     in_ch,
  apid_out_if.source  out_ch
);

  apid_pkg::cfg_t   cfg;
  apid_pkg::front_t front;
  apid_pkg::mix_t   law;
  logic             law_ready;
  logic             mix_ready;

  // Register file; values are used directly by the front, control law and mixer.
  apid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register and the feedback state of the loop.
  apid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .front    (front),
    .dn_ready (law_ready)
  );

  // Control law pipeline.
  apid_law u_law (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .front    (front),
    .up_ready (law_ready),
    .law      (law),
    .dn_ready (mix_ready)
  );

  // Clamp, mix and result register.
  apid_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .law      (law),
    .up_ready (mix_ready),
    .out_ch   (out_ch)
  );

endmodule
